FILE: hw/rtl/fdba_pkg.sv
// ----------------------------------------------------------------------------
// fdba_pkg
// Shared types and constants of the directory and block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fdba_pkg;

    localparam int BLOCK_COUNT_DEF = 64;
    localparam int ENTRY_COUNT_DEF = 20;
    localparam int BLOCK_BYTES     = 1024;

    localparam int NAME_BYTES = 31;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int FUNC_W     = 3;
    localparam int LEN_W      = 12;
    localparam int STATUS_W   = 3;
    localparam int BLK_W      = 6;
    localparam int SIZE_W     = 11;
    localparam int USED_W     = 7;

    localparam int S_DATA_W = 512;
    localparam int M_DATA_W = 32;
    localparam int RES_W    = STATUS_W + BLK_W + SIZE_W + USED_W;

    typedef enum logic [FUNC_W-1:0] {
        F_CREATE = 3'd0,
        F_WRITE  = 3'd1,
        F_READ   = 3'd2,
        F_DELETE = 3'd3,
        F_RENAME = 3'd4,
        F_FORMAT = 3'd5,
        F_USAGE  = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NO_BLOCK  = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_BLK,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [BLK_W-1:0]  blk;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic [USED_W-1:0] used;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  blk;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic capture;
        logic scan_en;
        logic blk_en;
        logic exec;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
        logic need_blk;
        logic blk_done;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/fdba_ctrl.sv
// ----------------------------------------------------------------------------
// fdba_ctrl
// Sequencer: accept a word, scan the directory, search the bitmap when a create
// needs a block, execute, hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdba_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire fdba_pkg::t_ctl_sts i_sts,
    output fdba_pkg::t_ctl_cmd      o_cmd
);

    fdba_pkg::t_state r_state;
    fdba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            fdba_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = fdba_pkg::S_SCAN;
                end
            end
            fdba_pkg::S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.need_blk ? fdba_pkg::S_BLK : fdba_pkg::S_EXEC;
                end
            end
            fdba_pkg::S_BLK: begin
                o_cmd.blk_en = 1'b1;
                if (i_sts.blk_done) begin
                    n_state = fdba_pkg::S_EXEC;
                end
            end
            fdba_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = fdba_pkg::S_DONE;
            end
            fdba_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = fdba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fdba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fdba_dpath.sv
// ----------------------------------------------------------------------------
// fdba_dpath
// Directory memory, entry and block bitmaps, scan counters, execute logic
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdba_dpath #(
    parameter int BLOCK_COUNT = fdba_pkg::BLOCK_COUNT_DEF,
    parameter int ENTRY_COUNT = fdba_pkg::ENTRY_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fdba_pkg::t_ctl_cmd            i_cmd,
    output fdba_pkg::t_ctl_sts                 o_sts,
    input  wire logic [fdba_pkg::S_DATA_W-1:0] i_s_tdata,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic      [fdba_pkg::M_DATA_W-1:0] o_m_tdata
);

    localparam int IW  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int ECW = $clog2(ENTRY_COUNT + 1);
    localparam int BW  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int BCW = $clog2(BLOCK_COUNT + 1);
    localparam int NW  = fdba_pkg::NAME_W;
    localparam int SZW = fdba_pkg::SIZE_W;
    localparam int BKW = fdba_pkg::BLK_W;
    localparam int LW  = fdba_pkg::LEN_W;
    localparam int UW  = fdba_pkg::USED_W;
    localparam int PAD_W = fdba_pkg::M_DATA_W - fdba_pkg::RES_W;

    function automatic logic [NW-1:0] clean_name(input logic [NW-1:0] raw);
        logic          ended;
        logic [7:0]    b;
        logic [NW-1:0] res;
        ended = 1'b0;
        res   = '0;
        for (int k = 0; k < fdba_pkg::NAME_BYTES; k++) begin
            b = raw[8*k +: 8];
            if (b == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                res[8*k +: 8] = b;
            end
        end
        return res;
    endfunction

    fdba_pkg::t_entry  r_mem [ENTRY_COUNT];

    fdba_pkg::t_func   r_func;
    logic [NW-1:0]     r_nm;
    logic [NW-1:0]     r_nn;
    logic [LW-1:0]     r_len;
    logic [NW-1:0]     n_nm;
    logic [NW-1:0]     n_nn;

    logic [ENTRY_COUNT-1:0] r_used;
    logic [BLOCK_COUNT-1:0] r_bitmap;
    logic [BCW-1:0]         r_cnt;

    logic [ECW-1:0]    r_idx;
    logic              r_cmp_v;
    logic [IW-1:0]     r_cmp_idx;
    fdba_pkg::t_entry  r_rdata;
    logic              r_hit_v;
    logic [IW-1:0]     r_hit_idx;
    logic [BKW-1:0]    r_hit_blk;
    logic [SZW-1:0]    r_hit_size;
    logic              r_nn_hit;
    logic              r_free_v;
    logic [IW-1:0]     r_free_idx;

    logic [BCW-1:0]    r_bidx;
    logic              r_bfree_v;
    logic [BW-1:0]     r_bfree_idx;

    fdba_pkg::t_result r_res;
    logic              r_m_valid;
    logic [fdba_pkg::M_DATA_W-1:0] r_m_data;

    logic              scan_last;
    logic              scan_done;
    logic              blk_done;
    logic              cmp_used;
    logic              nm_match;
    logic              nn_match;
    logic              out_free;
    logic [LW:0]       len_ext;
    logic [LW:0]       len_sat;

    fdba_pkg::t_result x_res;
    logic              x_we;
    logic [IW-1:0]     x_waddr;
    fdba_pkg::t_entry  x_wdata;
    logic              x_alloc;
    logic              x_release;
    logic              x_format;

    assign n_nm = clean_name(i_s_tdata[fdba_pkg::FUNC_W +: NW]);
    assign n_nn = clean_name(i_s_tdata[fdba_pkg::FUNC_W + NW +: NW]);

    assign scan_last = (r_idx == ECW'(ENTRY_COUNT));
    assign scan_done = scan_last && !r_cmp_v;
    assign blk_done  = r_bfree_v || (r_bidx == BCW'(BLOCK_COUNT));
    assign cmp_used  = r_used[r_cmp_idx];
    assign nm_match  = (r_rdata.name == r_nm);
    assign nn_match  = (r_rdata.name == r_nn);
    assign out_free  = !r_m_valid || i_m_tready;

    assign o_sts.scan_done = scan_done;
    assign o_sts.need_blk  = (r_func == fdba_pkg::F_CREATE) && !r_hit_v && r_free_v;
    assign o_sts.blk_done  = blk_done;
    assign o_sts.out_free  = out_free;

    assign len_ext = {1'b0, r_len};
    assign len_sat = (len_ext > (LW+1)'(fdba_pkg::BLOCK_BYTES)) ?
                     (LW+1)'(fdba_pkg::BLOCK_BYTES) : len_ext;

    always_comb begin
        x_res        = '0;
        x_res.status = fdba_pkg::ST_OK;
        x_we         = 1'b0;
        x_waddr      = r_hit_idx;
        x_wdata.name = r_nm;
        x_wdata.blk  = r_hit_blk;
        x_wdata.size = r_hit_size;
        x_alloc      = 1'b0;
        x_release    = 1'b0;
        x_format     = 1'b0;
        unique case (r_func)
            fdba_pkg::F_CREATE: begin
                priority if (r_hit_v) begin
                    x_res.status = fdba_pkg::ST_EXISTS;
                end else if (!r_free_v) begin
                    x_res.status = fdba_pkg::ST_FULL;
                end else if (!r_bfree_v) begin
                    x_res.status = fdba_pkg::ST_NO_BLOCK;
                end else begin
                    x_we         = 1'b1;
                    x_waddr      = r_free_idx;
                    x_wdata.blk  = BKW'(r_bfree_idx);
                    x_wdata.size = '0;
                    x_alloc      = 1'b1;
                    x_res.blk    = BKW'(r_bfree_idx);
                end
            end
            fdba_pkg::F_WRITE: begin
                if (!r_hit_v) begin
                    x_res.status = fdba_pkg::ST_NOT_FOUND;
                end else begin
                    x_we         = 1'b1;
                    x_wdata.size = len_sat[SZW-1:0];
                    x_res.size   = len_sat[SZW-1:0];
                end
            end
            fdba_pkg::F_READ: begin
                if (!r_hit_v) begin
                    x_res.status = fdba_pkg::ST_NOT_FOUND;
                end else begin
                    x_res.blk  = r_hit_blk;
                    x_res.size = r_hit_size;
                end
            end
            fdba_pkg::F_DELETE: begin
                if (!r_hit_v) begin
                    x_res.status = fdba_pkg::ST_NOT_FOUND;
                end else begin
                    x_release = 1'b1;
                end
            end
            fdba_pkg::F_RENAME: begin
                priority if (!r_hit_v) begin
                    x_res.status = fdba_pkg::ST_NOT_FOUND;
                end else if (r_nn_hit) begin
                    x_res.status = fdba_pkg::ST_EXISTS;
                end else begin
                    x_we         = 1'b1;
                    x_wdata.name = r_nn;
                end
            end
            fdba_pkg::F_FORMAT: begin
                x_format = 1'b1;
            end
            fdba_pkg::F_USAGE: begin
                x_res.used = UW'(r_cnt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_bitmap  <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
            r_cmp_v   <= 1'b0;
            r_hit_v   <= 1'b0;
            r_nn_hit  <= 1'b0;
            r_free_v  <= 1'b0;
            r_bidx    <= '0;
            r_bfree_v <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_idx     <= '0;
                r_cmp_v   <= 1'b0;
                r_hit_v   <= 1'b0;
                r_nn_hit  <= 1'b0;
                r_free_v  <= 1'b0;
                r_bidx    <= '0;
                r_bfree_v <= 1'b0;
            end
            if (i_cmd.scan_en) begin
                r_cmp_v <= !scan_last;
                if (!scan_last) begin
                    r_idx <= r_idx + ECW'(1);
                end
                if (r_cmp_v) begin
                    if (cmp_used && nm_match) begin
                        r_hit_v <= 1'b1;
                    end
                    if (cmp_used && nn_match) begin
                        r_nn_hit <= 1'b1;
                    end
                    if (!cmp_used) begin
                        r_free_v <= 1'b1;
                    end
                end
            end
            if (i_cmd.blk_en && !blk_done) begin
                if (!r_bitmap[r_bidx[BW-1:0]]) begin
                    r_bfree_v <= 1'b1;
                end else begin
                    r_bidx <= r_bidx + BCW'(1);
                end
            end
            if (i_cmd.exec) begin
                if (x_alloc) begin
                    r_used[r_free_idx]    <= 1'b1;
                    r_bitmap[r_bfree_idx] <= 1'b1;
                    r_cnt                 <= r_cnt + BCW'(1);
                end
                if (x_release) begin
                    r_used[r_hit_idx]         <= 1'b0;
                    r_bitmap[r_hit_blk[BW-1:0]] <= 1'b0;
                    r_cnt                     <= r_cnt - BCW'(1);
                end
                if (x_format) begin
                    r_used   <= '0;
                    r_bitmap <= '0;
                    r_cnt    <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= fdba_pkg::t_func'(i_s_tdata[fdba_pkg::FUNC_W-1:0]);
            r_nm   <= n_nm;
            r_nn   <= n_nn;
            r_len  <= i_s_tdata[fdba_pkg::FUNC_W + 2*NW +: LW];
        end
        if (i_cmd.scan_en) begin
            if (!scan_last) begin
                r_rdata   <= r_mem[r_idx[IW-1:0]];
                r_cmp_idx <= r_idx[IW-1:0];
            end
            if (r_cmp_v) begin
                if (cmp_used && nm_match && !r_hit_v) begin
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_blk  <= r_rdata.blk;
                    r_hit_size <= r_rdata.size;
                end
                if (!cmp_used && !r_free_v) begin
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
        if (i_cmd.blk_en && !blk_done) begin
            r_bfree_idx <= r_bidx[BW-1:0];
        end
        if (i_cmd.exec) begin
            r_res <= x_res;
            if (x_we) begin
                r_mem[x_waddr] <= x_wdata;
            end
        end
        if (i_cmd.load) begin
            r_m_data <= {PAD_W'(0), r_res};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

FILE: hw/rtl/file_directory_block_allocator.sv
// ----------------------------------------------------------------------------
// file_directory_block_allocator
// Sequence: a word is accepted in idle, the directory is scanned at one entry
// per cycle, a create that finds no match and a free entry then searches the
// bitmap at one bit per cycle, the command executes and the result waits for a
// free output register. A new word is taken only after that result is loaded.
// Reset frees all entries and blocks and empties the output at once.
// ----------------------------------------------------------------------------
`default_nettype none

module file_directory_block_allocator #(
    parameter int BLOCK_COUNT = fdba_pkg::BLOCK_COUNT_DEF,
    parameter int ENTRY_COUNT = fdba_pkg::ENTRY_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // func[2:0], name_word0..3, new_name_word0..3, text_length, zero pad
    input  wire logic [fdba_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status[2:0], block_index, file_size, used_blocks, zero pad
    output logic      [fdba_pkg::M_DATA_W-1:0] m_axis_tdata
);

    fdba_pkg::t_ctl_cmd cmd;
    fdba_pkg::t_ctl_sts sts;

    fdba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fdba_dpath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: verif/file_directory_block_allocator_checker.sv
// ----------------------------------------------------------------------------
// file_directory_block_allocator_checker
// Watches both stream channels of the directory and block allocator. Runs
// every accepted command word against a private copy of the directory and
// the block bitmap, queues the result word it predicts, and compares each
// result word leaving the block with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module file_directory_block_allocator_checker #(
    parameter int BLOCK_COUNT = fdba_pkg::BLOCK_COUNT_DEF,
    parameter int ENTRY_COUNT = fdba_pkg::ENTRY_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    // func[2:0], name_word0..3, new_name_word0..3, text_length, zero pad
    input  logic [fdba_pkg::S_DATA_W-1:0] i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    // status[2:0], block_index, file_size, used_blocks, zero pad
    input  logic [fdba_pkg::M_DATA_W-1:0] i_out_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import fdba_pkg::*;

    localparam int DUE_DEPTH = 16;

    logic              blk_map  [BLOCK_COUNT];
    logic              dir_used [ENTRY_COUNT];
    logic [NAME_W-1:0] dir_name [ENTRY_COUNT];
    logic [SIZE_W-1:0] dir_size [ENTRY_COUNT];
    logic [BLK_W-1:0]  dir_blk  [ENTRY_COUNT];

    t_result due_results [DUE_DEPTH];
    int      due_wr = 0;
    int      due_rd = 0;
    t_result want;
    t_result got;
    int      fails = 0;
    int      seen  = 0;

    function automatic void clear_directory();
        for (int i = 0; i < BLOCK_COUNT; i++) blk_map[i] = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            dir_used[i] = 1'b0;
            dir_name[i] = '0;
            dir_size[i] = '0;
            dir_blk[i]  = '0;
        end
    endfunction

    // drop every byte from the first zero byte on
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] nm;
        logic              ended;
        nm    = '0;
        ended = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (raw[8*k +: 8] == 8'h00) ended = 1'b1;
            if (!ended) nm[8*k +: 8] = raw[8*k +: 8];
        end
        return nm;
    endfunction

    function automatic int lookup(input logic [NAME_W-1:0] nm);
        int hit;
        hit = -1;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--)
            if (dir_used[i] && dir_name[i] == nm) hit = i;
        return hit;
    endfunction

    function automatic t_result run_command(input logic [S_DATA_W-1:0] word);
        t_result           r;
        t_func             f;
        logic [NAME_W-1:0] nm;
        logic [NAME_W-1:0] nn;
        int                len;
        int                e;
        int                b;
        int                n;
        r   = '0;
        f   = t_func'(word[FUNC_W-1:0]);
        nm  = trim_name(word[FUNC_W +: NAME_W]);
        nn  = trim_name(word[FUNC_W + NAME_W +: NAME_W]);
        len = int'(word[FUNC_W + 2*NAME_W +: LEN_W]);
        r.status = ST_OK;
        case (f)
            F_CREATE: begin
                if (lookup(nm) >= 0) begin
                    r.status = ST_EXISTS;
                end else begin
                    e = -1;
                    for (int i = ENTRY_COUNT - 1; i >= 0; i--) if (!dir_used[i]) e = i;
                    b = -1;
                    for (int i = BLOCK_COUNT - 1; i >= 0; i--) if (!blk_map[i]) b = i;
                    if (e < 0) begin
                        r.status = ST_FULL;
                    end else if (b < 0) begin
                        r.status = ST_NO_BLOCK;
                    end else begin
                        blk_map[b]  = 1'b1;
                        dir_used[e] = 1'b1;
                        dir_name[e] = nm;
                        dir_blk[e]  = BLK_W'(b);
                        dir_size[e] = '0;
                        r.blk       = BLK_W'(b);
                    end
                end
            end
            F_WRITE: begin
                e = lookup(nm);
                if (e < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.size      = SIZE_W'((len > BLOCK_BYTES) ? BLOCK_BYTES : len);
                    dir_size[e] = r.size;
                end
            end
            F_READ: begin
                e = lookup(nm);
                if (e < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.blk  = dir_blk[e];
                    r.size = dir_size[e];
                end
            end
            F_DELETE: begin
                e = lookup(nm);
                if (e < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    blk_map[dir_blk[e]] = 1'b0;
                    dir_used[e] = 1'b0;
                    dir_name[e] = '0;
                    dir_size[e] = '0;
                    dir_blk[e]  = '0;
                end
            end
            F_RENAME: begin
                e = lookup(nm);
                if (e < 0) r.status = ST_NOT_FOUND;
                else if (lookup(nn) >= 0) r.status = ST_EXISTS;
                else dir_name[e] = nn;
            end
            F_FORMAT: clear_directory();
            F_USAGE: begin
                n = 0;
                for (int i = 0; i < BLOCK_COUNT; i++) if (blk_map[i]) n++;
                r.used = USED_W'(n);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_directory();
            due_wr = 0;
            due_rd = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                due_results[due_wr % DUE_DEPTH] = run_command(i_in_data);
                due_wr++;
            end
            if (i_out_valid && i_out_ready) begin
                got = t_result'(i_out_data[RES_W-1:0]);
                if (due_wr == due_rd) begin
                    if (fails < 10)
                        $display("result %0d: none outstanding, got %h", seen, got);
                    fails++;
                end else begin
                    want = due_results[due_rd % DUE_DEPTH];
                    due_rd++;
                    if (got.status !== want.status || got.blk !== want.blk ||
                        got.size !== want.size || got.used !== want.used) begin
                        // fields: status blk size used
                        if (fails < 10)
                            $display("%0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     seen, want.status, want.blk, want.size, want.used,
                                     got.status, got.blk, got.size, got.used);
                        fails++;
                    end
                end
                seen++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_wr - due_rd;
    end

endmodule

FILE: verif/file_directory_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// file_directory_block_allocator_tb
// Drives directory commands into the allocator: a directed pass over the
// status codes, size saturation and name termination, then random commands
// over a small name pool so that the table fills, empties and gets renamed.
// Both sides stall at random in changing proportions, with one long output
// hold-off; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module file_directory_block_allocator_tb;
    import fdba_pkg::*;

    localparam int POOL_SIZE = 24;
    localparam int RANDOM_CMDS = 1250;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // func[2:0], name_word0..3, new_name_word0..3, text_length, zero pad
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // status[2:0], block_index, file_size, used_blocks, zero pad
    logic [M_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int stage        = 0;
    int tx_gap_pct   = 6;
    int rx_stall_pct = 52;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    logic [NAME_W-1:0] name_pool [POOL_SIZE];

    file_directory_block_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    file_directory_block_allocator_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("file_directory_block_allocator: mismatch");
        $finish;
    end

    // result side: random stalls, one long hold-off when the last stage opens
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stage == 2 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [NAME_W-1:0] random_name(input int n_bytes);
        logic [NAME_W-1:0] nm;
        nm = '0;
        for (int k = 0; k < n_bytes; k++) nm[8*k +: 8] = 8'($urandom_range(1, 255));
        return nm;
    endfunction

    // fill the bytes past the terminator with junk
    function automatic logic [NAME_W-1:0] with_tail(input logic [NAME_W-1:0] nm);
        logic [NAME_W-1:0] t;
        logic              ended;
        t     = nm;
        ended = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (ended) t[8*k +: 8] = 8'($urandom);
            if (nm[8*k +: 8] == 8'h00) ended = 1'b1;
        end
        return t;
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        logic [NAME_W-1:0] nm;
        if ($urandom_range(9) == 0) nm = random_name($urandom_range(0, NAME_BYTES));
        else nm = name_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(1) == 1) nm = with_tail(nm);
        return nm;
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        logic [LEN_W-1:0] len;
        case ($urandom_range(3))
            0: len = LEN_W'($urandom_range(4095));
            1: begin
                case ($urandom_range(4))
                    0: len = 12'd0;
                    1: len = 12'd1023;
                    2: len = 12'd1024;
                    3: len = 12'd1025;
                    default: len = 12'd4095;
                endcase
            end
            default: len = LEN_W'($urandom_range(1100));
        endcase
        return len;
    endfunction

    function automatic t_func pick_func();
        int r;
        r = $urandom_range(99);
        if (r < 35) return F_CREATE;
        if (r < 48) return F_WRITE;
        if (r < 61) return F_READ;
        if (r < 71) return F_DELETE;
        if (r < 83) return F_RENAME;
        if (r < 98) return F_USAGE;
        return F_FORMAT;
    endfunction

    task automatic issue(input t_func f, input logic [NAME_W-1:0] nm,
                         input logic [NAME_W-1:0] nn, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len, nn, nm, f};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [NAME_W-1:0] nm_a;
        logic [NAME_W-1:0] nm_b;
        logic [NAME_W-1:0] nm_c;
        logic [NAME_W-1:0] nm_full;
        logic [NAME_W-1:0] nm_x;
        logic [NAME_W-1:0] nn;
        t_func             f;

        name_pool[0] = '0;
        name_pool[1] = {NAME_BYTES{8'hFF}};
        for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = random_name($urandom_range(1, NAME_BYTES));
        nm_full = name_pool[1];
        nm_a    = name_pool[2];
        nm_b    = name_pool[3];
        nm_c    = name_pool[4];
        nm_x    = random_name(NAME_BYTES);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(F_USAGE,  nm_x, nm_x, 12'd0);
        issue(F_READ,   '0, nm_x, 12'd0);
        issue(F_CREATE, '0, nm_x, 12'd0);
        issue(F_CREATE, nm_full, '0, 12'd4095);
        issue(F_CREATE, nm_full, '0, 12'd0);
        issue(F_CREATE, with_tail(nm_a), '0, 12'd0);
        issue(F_CREATE, with_tail(nm_a), '0, 12'd0);
        issue(F_WRITE,  nm_a, '0, 12'd4095);
        issue(F_WRITE,  with_tail(nm_a), '0, 12'd1025);
        issue(F_WRITE,  nm_a, '0, 12'd1024);
        issue(F_READ,   nm_a, '0, 12'd0);
        issue(F_WRITE,  nm_a, '0, 12'd0);
        issue(F_WRITE,  nm_x, '0, 12'd100);
        issue(F_READ,   nm_x, '0, 12'd0);
        issue(F_DELETE, nm_x, '0, 12'd0);
        issue(F_RENAME, nm_x, nm_b, 12'd0);
        issue(F_RENAME, nm_a, with_tail(nm_a), 12'd0);
        issue(F_RENAME, nm_a, nm_full, 12'd0);
        issue(F_RENAME, nm_a, nm_b, 12'd0);
        issue(F_READ,   nm_a, '0, 12'd0);
        issue(F_READ,   nm_b, '0, 12'd0);
        issue(F_DELETE, '0, '0, 12'd0);
        issue(F_CREATE, nm_c, '0, 12'd0);
        issue(F_USAGE,  '0, '0, 12'd0);
        issue(F_FORMAT, nm_full, nm_full, 12'd4095);
        issue(F_USAGE,  '0, '0, 12'd0);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n == RANDOM_CMDS / 3) begin
                stage        = 1;
                tx_gap_pct   = 52;
                rx_stall_pct = 6;
            end else if (n == 2 * RANDOM_CMDS / 3) begin
                stage        = 2;
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            f  = pick_func();
            nm_x = pick_name();
            nn = ($urandom_range(9) == 0) ? with_tail(nm_x) : pick_name();
            issue(f, nm_x, nn, pick_len());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("file_directory_block_allocator: match");
        else
            $display("file_directory_block_allocator: mismatch");
        $finish;
    end

endmodule
